[src/rsgm_pkg.sv]
// ----------------------------------------------------------------------------
// rsgm_pkg
// Shared types, register codes, grid size and sine constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rsgm_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // grid edge in cells; the result fields carry 7-bit row and column
  localparam int unsigned GRID_DIM = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_MIN_RANGE   = 3'd2,
    REG_MAX_RANGE   = 3'd3,
    REG_CELL_SIZE   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ANGLE,
    S_SINX,
    S_MULX,
    S_SINY,
    S_MULY,
    S_DIVX,
    S_DIVY,
    S_CHECK,
    S_READ,
    S_DONE
  } state_t;

  // pi/2 in Q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

`default_nettype wire

[src/rsgm_in_if.sv]
// ----------------------------------------------------------------------------
// rsgm_in_if
// Range sample channel: beam index, range and robot pose.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsgm_in_if;
  logic               valid;
  logic               ready;
  logic [9:0]         beam_number;
  logic [15:0]        distance;
  logic signed [23:0] pose_x;
  logic signed [23:0] pose_y;
  logic [15:0]        heading;

  modport source (output valid, beam_number, distance, pose_x, pose_y, heading,
                  input ready);
  modport sink   (input valid, beam_number, distance, pose_x, pose_y, heading,
                  output ready);
endinterface

`default_nettype wire

[src/rsgm_out_if.sv]
// ----------------------------------------------------------------------------
// rsgm_out_if
// Result channel: grid cell and mark flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsgm_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cell_row;
  logic [6:0] cell_col;
  logic       marked;
  logic       already_set;

  modport source (output valid, cell_row, cell_col, marked, already_set,
                  input ready);
  modport sink   (input valid, cell_row, cell_col, marked, already_set,
                  output ready);
endinterface

`default_nettype wire

[src/rsgm_cfg_if.sv]
// ----------------------------------------------------------------------------
// rsgm_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsgm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/range_scan_to_grid_marker_unit.sv]
// ----------------------------------------------------------------------------
// range_scan_to_grid_marker_unit
// Projects one range sample into world space and marks its occupancy cell.
// ----------------------------------------------------------------------------
//  channel   dir   carries
//  in_bus    in    beam_number, distance, pose_x, pose_y, heading
//  out_bus   out   cell_row, cell_col, marked, already_set
//  cfg_bus   in    index, data (register write)
//
//  A sample passes through setup states (beam angle, two table lookups and
//  two products on the shared multiplier), two 26-step restoring divisions
//  by the cell size, then a registered read and a write of the grid memory;
//  a rejected range or beam skips to the result, an off-grid cell skips the
//  memory. A new sample is taken only in S_IDLE, after the last result loads.
//  After reset the grid is cleared one cell a cycle, with in_bus.ready low;
//  register writes are taken throughout.
//  A finished result waits in the output register while the next beat enters;
//  the following result holds the sequencer in S_DONE until out_bus drains.
// ----------------------------------------------------------------------------
`default_nettype none

module range_scan_to_grid_marker_unit
  import rsgm_pkg::*;
#(
  parameter int unsigned MAX_BEAMS    = 1024,
  parameter int unsigned SINE_ENTRIES = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rsgm_in_if.sink     in_bus,
  rsgm_out_if.source  out_bus,
  rsgm_cfg_if.sink    cfg_bus
);

  localparam int unsigned DEPTH  = GRID_DIM * GRID_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned RC_W   = $clog2(GRID_DIM);
  localparam int unsigned IDX_W  = $clog2(SINE_ENTRIES + 1);
  localparam int unsigned DVD_W  = 26;
  localparam int unsigned CNT_W  = $clog2(DVD_W);
  localparam int unsigned WLD_W  = 41;

  // sine table, built at elaboration: Taylor series up to x^15 in Q2.30 with
  // truncated terms, rounded half up to Q0.15 and saturated
  logic [14:0] sin_tab [0:SINE_ENTRIES];
  for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_sin
    localparam longint unsigned XK = (HALF_PI_Q30 * k) / SINE_ENTRIES;
    localparam longint unsigned X2 = (XK * XK) >> 30;
    localparam longint unsigned T1 = ((XK * X2) >> 30) / 6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / 156;
    localparam longint unsigned T7 = ((T6 * X2) >> 30) / 210;
    localparam longint SUM = longint'(XK) - longint'(T1) + longint'(T2) - longint'(T3)
                             + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
    localparam longint unsigned QR =
      (((SUM < 0) ? 64'd0 : unsigned'(SUM)) + 64'd16384) >> 15;
    localparam logic [14:0] QV = (QR > 64'd32767) ? 15'd32767 : 15'(QR);
    assign sin_tab[k] = QV;
  end

  // registers
  logic [15:0] start_angle_r, angle_step_r, min_range_r, max_range_r, cell_size_r;
  state_t      state_r, state_nxt;
  logic [9:0]  beam_r;
  logic [15:0] dist_r, head_r;
  logic signed [23:0] px_r, py_r;
  logic [15:0] ang_r;
  logic signed [15:0] sin_r;
  logic signed [WLD_W-1:0] wx_r, wy_r;
  logic        negx_r, negy_r;
  logic [DVD_W-1:0] qx_r;
  logic [16:0] rem_r;
  logic [DVD_W-1:0] dq_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic        rd_r;
  logic [RC_W-1:0] row_r, col_r;
  logic        out_valid_r;
  logic [6:0]  out_row_r, out_col_r;
  logic        out_mark_r, out_set_r;
  logic        res_mark_r;

  logic grid_mem [0:DEPTH-1];

  // control outputs
  logic in_fire, cfg_fire, out_load, div_last;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);
  assign div_last = (cnt_r == CNT_W'(DVD_W - 1));

  always_comb begin
    in_bus.ready  = (state_r == S_IDLE);
    cfg_bus.ready = 1'b1;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.cell_row    = out_row_r;
  assign out_bus.cell_col    = out_col_r;
  assign out_bus.marked      = out_mark_r;
  assign out_bus.already_set = out_set_r;

  // sine lookup for the angle of the current phase
  logic [15:0] ang_sel;
  logic [1:0]  quad;
  logic [IDX_W+14-1:0] idx_full;
  logic [IDX_W-1:0] idx;
  logic [14:0] mag;
  logic signed [15:0] sin_val;

  always_comb begin
    ang_sel  = (state_r == S_SINX) ? (ang_r + 16'd16384) : ang_r;
    quad     = ang_sel[15:14];
    idx_full = (IDX_W+14)'(ang_sel[13:0]) * (IDX_W+14)'(SINE_ENTRIES);
    idx      = idx_full[IDX_W+14-1:14];
    mag      = quad[0] ? sin_tab[IDX_W'(SINE_ENTRIES) - idx] : sin_tab[idx];
    sin_val  = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // shared multiplier
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;

  always_comb begin
    if (state_r == S_ANGLE) begin
      mul_a = $signed({7'd0, beam_r});
      mul_b = $signed({1'b0, angle_step_r});
    end else begin
      mul_a = $signed({1'b0, dist_r});
      mul_b = 17'(sin_r);
    end
    mul_p = mul_a * mul_b;
  end

  logic signed [WLD_W-1:0] world;
  assign world = ($signed({{(WLD_W-24){(state_r == S_MULX) ? px_r[23] : py_r[23]}},
                           (state_r == S_MULX) ? px_r : py_r}) <<< 15)
                 + WLD_W'(mul_p);

  // restoring divider step
  logic [15:0] dvsr;
  logic [16:0] rem_sh, rem_sub;
  logic        q_bit;
  logic [DVD_W-1:0] dq_nxt;

  always_comb begin
    dvsr    = (cell_size_r == 16'd0) ? 16'd1 : cell_size_r;
    rem_sh  = {rem_r[15:0], dq_r[DVD_W-1]};
    q_bit   = (rem_sh >= {1'b0, dvsr});
    rem_sub = q_bit ? (rem_sh - {1'b0, dvsr}) : rem_sh;
    dq_nxt  = {dq_r[DVD_W-2:0], q_bit};
  end

  function automatic logic [DVD_W-1:0] mag_shift(input logic signed [WLD_W-1:0] w);
    logic [WLD_W-1:0] a;
    a = w[WLD_W-1] ? WLD_W'(-w) : WLD_W'(w);
    return a[DVD_W+15-1:15];
  endfunction

  // cell check
  logic in_x, in_y, mark_ok, range_ok, beam_ok;

  always_comb begin
    in_x      = (qx_r < DVD_W'(GRID_DIM)) && (!negx_r || (qx_r == '0));
    in_y      = (dq_nxt < DVD_W'(GRID_DIM)) && (!negy_r || (dq_nxt == '0));
    mark_ok   = in_x && in_y;
    range_ok  = (dist_r > min_range_r) && (dist_r < max_range_r);
    beam_ok   = (32'(beam_r) < MAX_BEAMS);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_ANGLE;
      S_ANGLE: state_nxt = (range_ok && beam_ok) ? S_SINX : S_DONE;
      S_SINX:  state_nxt = S_MULX;
      S_MULX:  state_nxt = S_SINY;
      S_SINY:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_DIVX;
      S_DIVX:  if (div_last) state_nxt = S_DIVY;
      S_DIVY:  if (div_last) state_nxt = S_CHECK;
      S_CHECK: state_nxt = res_mark_r ? S_READ : S_DONE;
      S_READ:  state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      start_angle_r <= 16'd0;
      angle_step_r  <= 16'd182;
      min_range_r   <= 16'd100;
      max_range_r   <= 16'd10000;
      cell_size_r   <= 16'd50;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        unique case (cfg_bus.index)
          REG_START_ANGLE: start_angle_r <= cfg_bus.data;
          REG_ANGLE_STEP:  angle_step_r  <= cfg_bus.data;
          REG_MIN_RANGE:   min_range_r   <= cfg_bus.data;
          REG_MAX_RANGE:   max_range_r   <= cfg_bus.data;
          REG_CELL_SIZE:   cell_size_r   <= cfg_bus.data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      beam_r <= in_bus.beam_number;
      dist_r <= in_bus.distance;
      px_r   <= in_bus.pose_x;
      py_r   <= in_bus.pose_y;
      head_r <= in_bus.heading;
    end
    unique case (state_r)
      S_ANGLE: begin
        ang_r      <= start_angle_r + mul_p[15:0] + head_r;
        res_mark_r <= 1'b0;
        row_r      <= '0;
        col_r      <= '0;
      end
      S_SINX, S_SINY: sin_r <= sin_val;
      S_MULX: wx_r <= world;
      S_MULY: begin
        wy_r   <= world;
        negx_r <= wx_r[WLD_W-1];
        negy_r <= world[WLD_W-1];
        rem_r  <= '0;
        dq_r   <= mag_shift(wx_r);
        cnt_r  <= '0;
      end
      S_DIVX: begin
        if (div_last) begin
          qx_r  <= dq_nxt;
          rem_r <= '0;
          dq_r  <= mag_shift(wy_r);
          cnt_r <= '0;
        end else begin
          rem_r <= rem_sub;
          dq_r  <= dq_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_DIVY: begin
        cnt_r <= cnt_r + 1'b1;
        rem_r <= rem_sub;
        dq_r  <= dq_nxt;
        if (div_last) begin
          res_mark_r <= mark_ok;
          row_r      <= mark_ok ? qx_r[RC_W-1:0] : '0;
          col_r      <= mark_ok ? dq_nxt[RC_W-1:0] : '0;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_row_r  <= 7'(row_r);
      out_col_r  <= 7'(col_r);
      out_mark_r <= res_mark_r;
      out_set_r  <= res_mark_r && rd_r;
    end
  end

  // grid memory: clear sweep, registered read, set on mark
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we, mem_wd;

  always_comb begin
    mem_addr = ADDR_W'(row_r * ADDR_W'(GRID_DIM)) + ADDR_W'(col_r);
    mem_we   = (state_r == S_CLEAR) || (state_r == S_READ);
    mem_wd   = (state_r == S_READ);
    if (state_r == S_CLEAR) mem_addr = clr_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_addr] <= mem_wd;
    if (state_r == S_CHECK) rd_r <= grid_mem[mem_addr];
  end

endmodule

`default_nettype wire

[src/rsgm_checker.sv]
// ----------------------------------------------------------------------------
// rsgm_checker
// Port-level checks on the grid marker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsgm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] cell_row,
  input wire logic [6:0] cell_col,
  input wire logic       marked,
  input wire logic       already_set
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({cell_row, cell_col, marked, already_set}))
    else $error("result beat changed while stalled");

  // one sample in flight: no second beat right after one is taken
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_unmarked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !marked |-> cell_row == 7'd0 && cell_col == 7'd0 && !already_set)
    else $error("unmarked result carries nonzero fields");

  // a result appears only after a sample was taken well before
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too soon after input");

endmodule

bind range_scan_to_grid_marker_unit rsgm_checker u_rsgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .cell_row   (out_bus.cell_row),
  .cell_col   (out_bus.cell_col),
  .marked     (out_bus.marked),
  .already_set(out_bus.already_set)
);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives range samples through the grid marker under a series of register
// settings. Cell and mark flags come from the directed rows or are predicted
// from an independent sine table and occupancy map; each beat is checked.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rsgm_pkg::*;

  localparam int GRID_N    = 128;
  localparam int SIN_N     = 256;
  localparam int RAND_ITEMS = 1250;
  localparam logic [2:0] IDX_SPARE = 3'd7;   // no register behind this index

  typedef struct packed {
    logic [6:0] cell_row;
    logic [6:0] cell_col;
    logic       marked;
    logic       already_set;
  } mark_t;

  typedef struct {
    logic [9:0]         beam;
    logic [15:0]        rng;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0]        hd;
    bit                 typed;
    mark_t              want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  rsgm_in_if  in_bus ();
  rsgm_out_if out_bus ();
  rsgm_cfg_if cfg_bus ();

  range_scan_to_grid_marker_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus.sink),
    .out_bus (out_bus.source),
    .cfg_bus (cfg_bus.sink)
  );

  // local copy of the block state
  logic [15:0] start_a, step_a, min_r, max_r, cell_mm;
  bit          occ [GRID_N*GRID_N];
  int          sin_tab [SIN_N+1];
  mark_t       cell_q [$];
  int          errors;
  int          next_gap;
  bit          burst;
  bit          rx_burst;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int taylor_q15(int k);
    longint unsigned x, x2, term, q;
    longint          sum;
    x    = (64'd1686629713 * longint'(k)) / SIN_N;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    q = (unsigned'(sum) + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return int'(q);
  endfunction

  function automatic int sine_q15(logic [15:0] a);
    int idx, mag;
    idx = (int'(a[13:0]) * SIN_N) >> 14;
    mag = a[14] ? sin_tab[SIN_N - idx] : sin_tab[idx];
    return a[15] ? -mag : mag;
  endfunction

  // project one sample and update the occupancy map
  function automatic mark_t project_sample(logic [9:0] beam, logic [15:0] rng,
                                           logic signed [23:0] px,
                                           logic signed [23:0] py,
                                           logic [15:0] hd);
    mark_t       r;
    logic [15:0] ang;
    longint      wx, wy, dv, row, col;
    r = '0;
    if (!(rng > min_r && rng < max_r)) return r;
    ang = start_a + beam * step_a + hd;
    wx  = longint'(px) * 32768 + longint'(rng) * sine_q15(ang + 16'd16384);
    wy  = longint'(py) * 32768 + longint'(rng) * sine_q15(ang);
    dv  = longint'(cell_mm == 0 ? 16'd1 : cell_mm) * 32768;
    row = wx / dv;
    col = wy / dv;
    if (row < 0 || row >= GRID_N || col < 0 || col >= GRID_N) return r;
    r.cell_row    = row[6:0];
    r.cell_col    = col[6:0];
    r.marked      = 1'b1;
    r.already_set = occ[row * GRID_N + col];
    occ[row * GRID_N + col] = 1'b1;
    return r;
  endfunction

  function automatic int pick_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_START_ANGLE: start_a = val;
      REG_ANGLE_STEP:  step_a  = val;
      REG_MIN_RANGE:   min_r   = val;
      REG_MAX_RANGE:   max_r   = val;
      REG_CELL_SIZE:   cell_mm = val;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // send one beat; keep valid high when the next beat follows at once
  task automatic send_sample(logic [9:0] beam, logic [15:0] rng,
                             logic signed [23:0] px, logic signed [23:0] py,
                             logic [15:0] hd, bit typed, mark_t want);
    mark_t got;
    repeat (next_gap) @(posedge clk);
    in_bus.valid       <= 1'b1;
    in_bus.beam_number <= beam;
    in_bus.distance    <= rng;
    in_bus.pose_x      <= px;
    in_bus.pose_y      <= py;
    in_bus.heading     <= hd;
    do @(posedge clk); while (!in_bus.ready);
    got = project_sample(beam, rng, px, py, hd);
    cell_q.push_back(typed ? want : got);
    next_gap = pick_gap(burst);
    if (next_gap != 0) in_bus.valid <= 1'b0;
  endtask

  task automatic drain_results();
    if (next_gap == 0) in_bus.valid <= 1'b0;
    next_gap = 1;
    while (cell_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_sample();
    int                 c, span;
    logic [9:0]         beam;
    logic [15:0]        rng;
    logic signed [23:0] px, py;
    c    = (cell_mm == 0) ? 1 : cell_mm;
    span = GRID_N * c;
    if (span > 8388607) span = 8388607;
    beam = 10'($urandom);
    rng  = 16'($urandom);
    px   = 24'($urandom);
    py   = 24'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      px = 24'($urandom_range(0, span));
      py = 24'($urandom_range(0, span));
      if (int'(min_r) + 1 < int'(max_r))
        rng = 16'($urandom_range(int'(min_r) + 1,
                                 (int'(max_r) - 1 < int'(min_r) + span) ?
                                 int'(max_r) - 1 : int'(min_r) + span));
    end
    send_sample(beam, rng, px, py, 16'($urandom), 1'b0, '0);
  endtask

  // receive side: check each beat, then stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        mark_t seen, want;
        seen = {out_bus.cell_row, out_bus.cell_col, out_bus.marked,
                out_bus.already_set};
        if (cell_q.size() == 0) begin
          $display("%0t: unexpected beat row=%0d col=%0d marked=%0b already=%0b",
                   $time, seen.cell_row, seen.cell_col, seen.marked,
                   seen.already_set);
          errors++;
        end else begin
          want = cell_q.pop_front();
          if (seen !== want) begin
            $display("%0t: mismatch expected row=%0d col=%0d marked=%0b already=%0b, actual row=%0d col=%0d marked=%0b already=%0b",
                     $time, want.cell_row, want.cell_col, want.marked,
                     want.already_set, seen.cell_row, seen.cell_col,
                     seen.marked, seen.already_set);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(rx_burst);
        out_bus.ready <= (stall_left == 0);
      end
    end
  end

  stim_row_t dir_rows [21] = '{
    '{10'd0,    16'd1000,  24'sd0,       24'sd0,    16'd0,     1'b1, '{7'd19, 7'd0, 1'b1, 1'b0}},
    '{10'd0,    16'd1000,  24'sd0,       24'sd0,    16'd0,     1'b1, '{7'd19, 7'd0, 1'b1, 1'b1}},
    '{10'd0,    16'd100,   24'sd0,       24'sd0,    16'd0,     1'b1, '0},
    '{10'd0,    16'd10000, 24'sd0,       24'sd0,    16'd0,     1'b1, '0},
    '{10'd0,    16'd0,     24'sd0,       24'sd0,    16'd0,     1'b1, '0},
    '{10'd0,    16'd65535, 24'sd3000,    24'sd3000, 16'd0,     1'b1, '0},
    '{10'd0,    16'd101,   24'sd0,       24'sd0,    16'd0,     1'b1, '{7'd2, 7'd0, 1'b1, 1'b0}},
    '{10'd0,    16'd9999,  24'sd0,       24'sd0,    16'd0,     1'b1, '0},
    '{10'd0,    16'd1000,  24'sd0,       24'sd0,    16'd32768, 1'b1, '0},
    '{10'd0,    16'd1000,  24'sd8388607, 24'sd0,    16'd0,     1'b1, '0},
    '{10'd0,    16'd1000,  -24'sd8388608,24'sd0,    16'd0,     1'b1, '0},
    '{10'd0,    16'd1000,  24'sd0,       24'sd0,    16'd16384, 1'b1, '{7'd0, 7'd19, 1'b1, 1'b0}},
    '{10'd1023, 16'd2000,  24'sd3200,    24'sd3200, 16'd65535, 1'b0, '0},
    '{10'd512,  16'd1500,  24'sd3000,    24'sd3000, 16'd8192,  1'b0, '0},
    '{10'd512,  16'd1500,  24'sd3000,    24'sd3000, 16'd24576, 1'b0, '0},
    '{10'd512,  16'd1500,  24'sd3000,    24'sd3000, 16'd40960, 1'b0, '0},
    '{10'd512,  16'd1500,  24'sd3000,    24'sd3000, 16'd57344, 1'b0, '0},
    '{10'd0,    16'd150,   24'sd6399,    24'sd6399, 16'd0,     1'b0, '0},
    '{10'd0,    16'd2000,  -24'sd1000,   24'sd3200, 16'd0,     1'b0, '0},
    '{10'd0,    16'd200,   24'sd6300,    24'sd6350, 16'd0,     1'b0, '0},
    '{10'd777,  16'd4321,  24'sd100,     -24'sd30,  16'd1234,  1'b0, '0}
  };

  initial begin
    int n;
    errors     = 0;
    next_gap   = 0;
    burst      = 1'b0;
    rx_burst   = 1'b0;
    stall_left = 0;
    rst_n      = 1'b0;
    start_a = 16'd0; step_a = 16'd182; min_r = 16'd100; max_r = 16'd10000;
    cell_mm = 16'd50;
    for (int i = 0; i < GRID_N * GRID_N; i++) occ[i] = 1'b0;
    for (int k = 0; k <= SIN_N; k++) sin_tab[k] = taylor_q15(k);
    in_bus.valid = 1'b0; in_bus.beam_number = '0; in_bus.distance = '0;
    in_bus.pose_x = '0; in_bus.pose_y = '0; in_bus.heading = '0;
    cfg_bus.valid = 1'b0; cfg_bus.index = '0; cfg_bus.data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_sample(dir_rows[i].beam, dir_rows[i].rng, dir_rows[i].px,
                  dir_rows[i].py, dir_rows[i].hd, dir_rows[i].typed,
                  dir_rows[i].want);
    drain_results();

    // phases: defaults, extremes of every register, then mixed settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_START_ANGLE, 16'd65535);
          write_reg(REG_ANGLE_STEP, 16'd65535);
          write_reg(IDX_SPARE, 16'hFFFF);
        end
        2: begin
          write_reg(REG_MIN_RANGE, 16'd0);
          write_reg(REG_MAX_RANGE, 16'd65535);
          write_reg(REG_CELL_SIZE, 16'd1);
          write_reg(REG_ANGLE_STEP, 16'd0);
        end
        3: write_reg(REG_CELL_SIZE, 16'd0);
        4: begin
          write_reg(REG_CELL_SIZE, 16'd65535);
          write_reg(REG_START_ANGLE, 16'd16384);
          write_reg(REG_ANGLE_STEP, 16'd64);
        end
        5: begin
          write_reg(REG_CELL_SIZE, 16'd20);
          write_reg(REG_MIN_RANGE, 16'd65535);
          write_reg(REG_MAX_RANGE, 16'd0);
        end
        6: begin
          write_reg(REG_MIN_RANGE, 16'd50);
          write_reg(REG_MAX_RANGE, 16'd3000);
          write_reg(REG_START_ANGLE, 16'($urandom));
          write_reg(REG_ANGLE_STEP, 16'($urandom));
        end
        7: begin
          write_reg(REG_CELL_SIZE, 16'd7);
          write_reg(REG_MIN_RANGE, 16'd0);
          write_reg(REG_MAX_RANGE, 16'd2000);
        end
        default: ;
      endcase
      burst    = (ph == 2);
      rx_burst = (ph == 4);
      n = (ph == 5) ? 60 : (RAND_ITEMS - 60) / 7;
      repeat (n) random_sample();
      drain_results();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
src/rsgm_pkg.sv
src/rsgm_in_if.sv
src/rsgm_out_if.sv
src/rsgm_cfg_if.sv
src/range_scan_to_grid_marker_unit.sv
src/rsgm_checker.sv
verif/tb_top.sv
